// ----- hw/rtl/csvfe_pkg.sv -----
// Shared types and constants for the CSV column field extractor.
// No dependencies; imported by every other RTL file of the block but the checker.
`default_nettype none

package csvfe_pkg;

  // Special characters of the line grammar
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Register index, taken from paddr[2]
  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam int PADDR_W = 3;

  // Flags that ride with one read request from front to back
  typedef struct packed {
    logic valid;  // request carries a stored byte
    logic found;  // line reached the target column
    logic last;   // final result of the line
  } cmd_flags_t;

  localparam int FLAGS_W = $bits(cmd_flags_t);

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/csv_column_field_extractor.sv -----
// A request enters the read queue when accepted; its store read then goes into the
// output register, and it waits in the queue while the output stalls.
// Throughput: one line byte per cycle while in_stall is low; drained bytes one per
// request per cycle. The first byte of a new line waits until the read queue is empty,
// once the previous line's last request has left it, later if the output stalls.
// Reset (rst, synchronous): clears line state, queue and output valid; registers
// return to target_column 0, field_limit 64. The field store is not cleared.
`default_nettype none

module csv_column_field_extractor
  import csvfe_pkg::*;
#(
  parameter int FIELD_CAP = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // line byte requests
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         line_byte,
  input  wire logic               line_last,
  // field results
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              field_byte,
  output logic                    byte_valid,
  output logic                    column_found,
  output logic                    last_of_field
);

  localparam int AW = $clog2(FIELD_CAP);
  localparam int QW = AW + FLAGS_W;

  logic [7:0]    target_column;
  logic [6:0]    field_limit;
  logic          cfg_wr;

  logic          push, pop, q_empty, q_full;
  logic [AW-1:0] push_addr;
  cmd_flags_t    push_flags;
  logic [QW-1:0] q_head;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // Register file: zero-wait writes, reads decoded on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_column <= 8'd0;
      field_limit   <= 7'd64;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TARGET: target_column <= pwdata[7:0];
        REG_LIMIT:  field_limit   <= pwdata[6:0];
        default:    target_column <= target_column;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TARGET: prdata = {24'd0, target_column};
      REG_LIMIT:  prdata = {25'd0, field_limit};
      default:    prdata = 32'd0;
    endcase
  end

  // Front: column/quote tracking, store writes, trim bounds, read requests
  csvfe_front #(.FIELD_CAP(FIELD_CAP)) u_front (
    .clk           (clk),
    .rst           (rst),
    .target_column (target_column),
    .field_limit   (field_limit),
    .in_valid      (in_valid),
    .line_byte     (line_byte),
    .line_last     (line_last),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .q_empty       (q_empty),
    .push          (push),
    .push_addr     (push_addr),
    .push_flags    (push_flags),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  // Short queue decouples request issue from output back-pressure
  csvfe_fifo #(.W(QW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_addr, push_flags}),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back: store read (registered) straight into the output register
  csvfe_back #(.FIELD_CAP(FIELD_CAP)) u_back (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .q_empty       (q_empty),
    .q_addr        (q_head[QW-1:FLAGS_W]),
    .q_flags       (cmd_flags_t'(q_head[FLAGS_W-1:0])),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .field_byte    (field_byte),
    .byte_valid    (byte_valid),
    .column_found  (column_found),
    .last_of_field (last_of_field)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/csvfe_front.sv -----
// Front part: accepts line bytes, tracks columns and quotes, writes the field
// store and issues read requests. Depends on csvfe_pkg.
`default_nettype none

module csvfe_front
  import csvfe_pkg::*;
#(
  parameter int FIELD_CAP = 64,
  localparam int AW = $clog2(FIELD_CAP)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    target_column,
  input  wire logic [6:0]    field_limit,
  input  wire logic          in_valid,
  input  wire logic [7:0]    line_byte,
  input  wire logic          line_last,
  output logic               in_stall,
  input  wire logic          q_full,
  input  wire logic          q_empty,
  output logic               push,
  output logic [AW-1:0]      push_addr,
  output cmd_flags_t         push_flags,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data
);

  localparam int LW = (AW + 1 > 7) ? AW + 1 : 7;

  logic [7:0]    column_count, column_count_next;
  logic          quote_mode, quote_mode_next;
  logic          field_closed, field_closed_next;
  logic [AW-1:0] stored_count, stored_count_next;
  logic          has_nb, has_nb_next;
  logic [AW-1:0] first_nb, first_nb_next;
  logic [AW-1:0] last_nb, last_nb_next;
  logic          drain_on, drain_on_next;
  logic [AW-1:0] drain_pos, drain_pos_next;
  logic [AW-1:0] drain_end, drain_end_next;
  logic          drain_found, drain_found_next;

  logic          accept;
  logic [LW-1:0] lim, keep;
  logic          at_target;
  logic          found;

  // drain requests need a queue slot; a new line byte waits until every
  // read of the previous line has left the queue (store reuse)
  assign in_stall = drain_on ? q_full : !q_empty;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    lim  = (LW'(field_limit) > LW'(FIELD_CAP)) ? LW'(FIELD_CAP) : LW'(field_limit);
    keep = (lim == '0) ? '0 : lim - LW'(1);
  end

  assign at_target = (column_count == target_column);

  always_comb begin
    column_count_next = column_count;
    quote_mode_next   = quote_mode;
    field_closed_next = field_closed;
    stored_count_next = stored_count;
    has_nb_next       = has_nb;
    first_nb_next     = first_nb;
    last_nb_next      = last_nb;
    drain_on_next     = drain_on;
    drain_pos_next    = drain_pos;
    drain_end_next    = drain_end;
    drain_found_next  = drain_found;
    push              = 1'b0;
    push_addr         = '0;
    push_flags        = '0;
    wr_en             = 1'b0;
    wr_addr           = stored_count;
    wr_data           = line_byte;
    found             = 1'b0;

    if (accept) begin
      if (drain_on) begin
        push             = 1'b1;
        push_addr        = drain_pos;
        push_flags.valid = 1'b1;
        push_flags.found = drain_found;
        push_flags.last  = ({1'b0, drain_pos} + (AW+1)'(1)) == {1'b0, drain_end};
        drain_pos_next   = drain_pos + AW'(1);
        if (push_flags.last) begin
          drain_on_next = 1'b0;
        end
      end else begin
        if (line_byte != CH_NUL && !field_closed) begin
          if (line_byte == CH_QUOTE) begin
            quote_mode_next = !quote_mode;
          end else if (line_byte == CH_COMMA && !quote_mode) begin
            if (at_target) begin
              field_closed_next = 1'b1;
            end else begin
              column_count_next = column_count + 8'd1;
            end
          end else if (at_target && (LW'(stored_count) < keep)) begin
            wr_en             = 1'b1;
            stored_count_next = stored_count + AW'(1);
            if (!is_blank(line_byte)) begin
              if (!has_nb) begin
                first_nb_next = stored_count;
              end
              last_nb_next = stored_count;
              has_nb_next  = 1'b1;
            end
          end
        end

        if (line_last) begin
          found            = (column_count_next == target_column);
          push             = 1'b1;
          push_flags.found = found;
          if (!has_nb_next) begin
            // empty field after trim
            push_flags.valid = 1'b0;
            push_flags.last  = 1'b1;
          end else begin
            push_addr        = first_nb_next;
            push_flags.valid = 1'b1;
            push_flags.last  = (first_nb_next == last_nb_next);
            if (first_nb_next != last_nb_next) begin
              drain_on_next    = 1'b1;
              drain_pos_next   = first_nb_next + AW'(1);
              drain_end_next   = last_nb_next + AW'(1);
              drain_found_next = found;
            end
          end
          column_count_next = '0;
          quote_mode_next   = 1'b0;
          field_closed_next = 1'b0;
          stored_count_next = '0;
          has_nb_next       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      quote_mode   <= 1'b0;
      field_closed <= 1'b0;
      stored_count <= '0;
      has_nb       <= 1'b0;
      drain_on     <= 1'b0;
      drain_found  <= 1'b0;
    end else begin
      column_count <= column_count_next;
      quote_mode   <= quote_mode_next;
      field_closed <= field_closed_next;
      stored_count <= stored_count_next;
      has_nb       <= has_nb_next;
      drain_on     <= drain_on_next;
      drain_found  <= drain_found_next;
    end
  end

  // index registers, meaningful only under their flags
  always_ff @(posedge clk) begin
    first_nb  <= first_nb_next;
    last_nb   <= last_nb_next;
    drain_pos <= drain_pos_next;
    drain_end <= drain_end_next;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/csvfe_fifo.sv -----
// Two-entry request queue between front and back.
// Depends on csvfe_pkg for the flag width used by its callers.
`default_nettype none

module csvfe_fifo
  import csvfe_pkg::*;
#(
  parameter int W = 9
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      head,
  output logic              empty,
  output logic              full
);

  logic [W-1:0] slot [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/csvfe_back.sv -----
// Back part: holds the field store, serves queued read requests and keeps
// the output register. Depends on csvfe_pkg.
`default_nettype none

module csvfe_back
  import csvfe_pkg::*;
#(
  parameter int FIELD_CAP = 64,
  localparam int AW = $clog2(FIELD_CAP)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          q_empty,
  input  wire logic [AW-1:0] q_addr,
  input  cmd_flags_t         q_flags,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         field_byte,
  output logic               byte_valid,
  output logic               column_found,
  output logic               last_of_field
);

  logic [7:0] store [FIELD_CAP];
  logic [7:0] rd_data;
  cmd_flags_t out_flags;

  assign pop = !q_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (pop) begin
      rd_data <= store[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_flags <= q_flags;
    end
  end

  assign field_byte    = out_flags.valid ? rd_data : 8'h00;
  assign byte_valid    = out_flags.valid;
  assign column_found  = out_flags.found;
  assign last_of_field = out_flags.last;

endmodule

`default_nettype wire

// ----- hw/rtl/csvfe_checker.sv -----
// Port-level checks for the CSV column field extractor, bound to the top level.
// Depends on csvfe_pkg only through the bound top level's port widths.
`default_nettype none

module csvfe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] field_byte,
  input wire logic       byte_valid,
  input wire logic       column_found,
  input wire logic       last_of_field
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_byte) &&
      $stable(last_of_field))
    else $error("stalled result changed");

  // empty result is a zero byte and closes the line
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> field_byte == 8'h00 && last_of_field)
    else $error("empty result malformed");

  // a presented result carries defined fields
  a_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({field_byte, byte_valid, column_found, last_of_field}))
    else $error("unknown result field");

  // a stored byte is never a NUL
  a_no_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> field_byte != 8'h00)
    else $error("NUL byte emitted");

endmodule

bind csv_column_field_extractor csvfe_checker u_csvfe_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .field_byte    (field_byte),
  .byte_valid    (byte_valid),
  .column_found  (column_found),
  .last_of_field (last_of_field)
);

`default_nettype wire
